@@ rtl/obb_pkg.sv @@
// Shared constants and types for the oriented box overlap test.
// Holds the corner store geometry, the read command codes and the command struct.
// No dependencies.
`default_nettype none

package obb_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int CORNER_DEPTH   = 8;
  localparam int CORNER_ADDR_W  = 3;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_PREV = 2'd1;
  localparam logic [1:0] OP_AXIS = 2'd2;
  localparam logic [1:0] OP_PROJ = 2'd3;

  typedef struct packed {
    logic [1:0]               op;
    logic [CORNER_ADDR_W-1:0] addr;
  } rd_cmd_t;

endpackage

`default_nettype wire

@@ rtl/oriented_box_overlap_test.sv @@
// Oriented box overlap test, top level: separating axis test on two rectangles.
// Instantiates obb_corner_ram, obb_proj_unit and obb_seq; uses obb_pkg.
//
// Usage: each input word carries one world-space corner (box, index, x, y) in signed
// Q12.4 and is written into an eight-entry corner store. A word without last_corner
// is stored and yields no result. A word with last_corner is stored and then starts
// the test: four axes, each of thirteen steps on the single read port of the corner
// store (two reads for the axis, eight projection reads, pipeline drain and compare).
// The result word appears on the out channel after all four axes are checked, so a
// full pair test costs eight corner words plus the test.
// in_stall is high while a test runs and until its result is loaded into the output
// register. If the receiver stalls, the result holds in that register; further
// corner words are still taken; a new test runs, but its result waits for the register.
// Reset clears the control state and the output valid; the corner store contents
// stay undefined until written.
`default_nettype none

module oriented_box_overlap_test #(
  parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_box_select,
  input  wire logic [1:0]                   in_corner_index,
  input  wire logic signed [COORD_BITS-1:0] in_corner_x,
  input  wire logic signed [COORD_BITS-1:0] in_corner_y,
  input  wire logic                         in_last_corner,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_overlapping
);

  logic                    in_accept;
  logic                    busy;
  logic                    separated;
  logic [2*COORD_BITS-1:0] rd_data;
  obb_pkg::rd_cmd_t        cmd;

  assign in_stall  = busy;
  assign in_accept = in_valid && !busy;

  obb_corner_ram #(
    .COORD_BITS(COORD_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (in_accept),
    .wr_addr ({in_box_select, in_corner_index}),
    .wr_data ({in_corner_y, in_corner_x}),
    .rd_addr (cmd.addr),
    .rd_data (rd_data)
  );

  obb_proj_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .rd_data   (rd_data),
    .separated (separated)
  );

  obb_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (in_accept && in_last_corner),
    .separated       (separated),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_overlapping (out_overlapping)
  );

endmodule

`default_nettype wire

@@ rtl/obb_corner_ram.sv @@
// Corner store: eight entries of packed x and y coordinates.
// One write port, one synchronous read port whose data is registered.
// Uses obb_pkg for the store geometry.
`default_nettype none

module obb_corner_ram #(
  parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               wr_en,
  input  wire logic [obb_pkg::CORNER_ADDR_W-1:0]  wr_addr,
  input  wire logic [2*COORD_BITS-1:0]            wr_data,
  input  wire logic [obb_pkg::CORNER_ADDR_W-1:0]  rd_addr,
  output logic      [2*COORD_BITS-1:0]            rd_data
);

  logic [2*COORD_BITS-1:0] mem [obb_pkg::CORNER_DEPTH];
  logic [2*COORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/obb_proj_unit.sv @@
// Projection datapath: forms an axis from two stored corners, projects corners onto it
// and tracks the projection interval of each box. Depends on obb_pkg for command codes.
// The read data arrives in the cycle after the command that addressed it.
`default_nettype none

module obb_proj_unit #(
  parameter int COORD_BITS = obb_pkg::COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire obb_pkg::rd_cmd_t        cmd,
  input  wire logic [2*COORD_BITS-1:0] rd_data,
  output logic                         separated
);

  localparam int AX_W   = COORD_BITS + 1;
  localparam int PROD_W = 2 * COORD_BITS + 1;
  localparam int SUM_W  = 2 * COORD_BITS + 2;

  obb_pkg::rd_cmd_t cmd1_r;

  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [COORD_BITS-1:0] prev_x_r;
  logic signed [COORD_BITS-1:0] prev_y_r;
  logic signed [AX_W-1:0]       ax_r;
  logic signed [AX_W-1:0]       ay_r;
  logic signed [PROD_W-1:0]     px_r;
  logic signed [PROD_W-1:0]     py_r;
  logic                         prod_v_r;
  logic                         prod_box_r;
  logic                         prod_first_r;
  logic signed [SUM_W-1:0]      sum;
  logic signed [SUM_W-1:0]      min_r [2];
  logic signed [SUM_W-1:0]      max_r [2];

  assign cur_x = rd_data[COORD_BITS-1:0];
  assign cur_y = rd_data[2*COORD_BITS-1:COORD_BITS];
  assign sum   = SUM_W'(px_r) + SUM_W'(py_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd1_r   <= '{op: obb_pkg::OP_NONE, addr: '0};
      prod_v_r <= 1'b0;
    end else begin
      cmd1_r   <= cmd;
      prod_v_r <= (cmd1_r.op == obb_pkg::OP_PROJ);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd1_r.op)
      obb_pkg::OP_PREV: begin
        prev_x_r <= cur_x;
        prev_y_r <= cur_y;
      end
      obb_pkg::OP_AXIS: begin
        ax_r <= AX_W'(cur_x) - AX_W'(prev_x_r);
        ay_r <= AX_W'(cur_y) - AX_W'(prev_y_r);
      end
      obb_pkg::OP_PROJ: begin
        px_r <= PROD_W'(cur_x) * PROD_W'(ax_r);
        py_r <= PROD_W'(cur_y) * PROD_W'(ay_r);
      end
      default: begin
      end
    endcase
    prod_box_r   <= cmd1_r.addr[2];
    prod_first_r <= (cmd1_r.addr[1:0] == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (prod_v_r) begin
      if (prod_first_r || (sum < min_r[prod_box_r])) begin
        min_r[prod_box_r] <= sum;
      end
      if (prod_first_r || (sum > max_r[prod_box_r])) begin
        max_r[prod_box_r] <= sum;
      end
    end
  end

  assign separated = (max_r[0] < min_r[1]) || (max_r[1] < min_r[0]);

endmodule

`default_nettype wire

@@ rtl/obb_seq.sv @@
// Test sequencer: walks the four axes, issues corner store reads and gathers the
// separation verdict into the output register. Depends on obb_pkg for command codes.
// Thirteen steps per axis: two axis reads, eight projection reads, drain and check.
`default_nettype none

module obb_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             separated,
  input  wire logic             out_stall,
  output obb_pkg::rd_cmd_t      cmd,
  output logic                  busy,
  output logic                  out_valid,
  output logic                  out_overlapping
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [3:0] STEP_PREV  = 4'd0;
  localparam logic [3:0] STEP_AXIS  = 4'd1;
  localparam logic [3:0] STEP_PROJ0 = 4'd2;
  localparam logic [3:0] STEP_PROJ7 = 4'd9;
  localparam logic [3:0] STEP_CHECK = 4'd12;

  logic [1:0] state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [3:0] step_r, step_nxt;
  logic       sep_any_r, sep_any_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_ovl_r, out_ovl_nxt;
  logic [obb_pkg::CORNER_ADDR_W-1:0] proj_addr;

  assign proj_addr = obb_pkg::CORNER_ADDR_W'(step_r - STEP_PROJ0);

  always_comb begin
    cmd = '{op: obb_pkg::OP_NONE, addr: '0};
    if (state_r == ST_RUN) begin
      if (step_r == STEP_PREV) begin
        cmd.op   = obb_pkg::OP_PREV;
        cmd.addr = {axis_r[1], (axis_r[0] ? 2'd1 : 2'd2)};
      end else if (step_r == STEP_AXIS) begin
        cmd.op   = obb_pkg::OP_AXIS;
        cmd.addr = {axis_r[1], (axis_r[0] ? 2'd2 : 2'd3)};
      end else if (step_r >= STEP_PROJ0 && step_r <= STEP_PROJ7) begin
        cmd.op   = obb_pkg::OP_PROJ;
        cmd.addr = proj_addr;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    step_nxt      = step_r;
    sep_any_nxt   = sep_any_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ovl_nxt   = out_ovl_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt   = ST_RUN;
          axis_nxt    = 2'd0;
          step_nxt    = STEP_PREV;
          sep_any_nxt = 1'b0;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_CHECK) begin
          sep_any_nxt = sep_any_r | separated;
          step_nxt    = STEP_PREV;
          axis_nxt    = axis_r + 2'd1;
          if (axis_r == 2'd3) begin
            state_nxt = ST_DONE;
          end
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ovl_nxt   = !sep_any_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= 2'd0;
      step_r      <= STEP_PREV;
      sep_any_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      step_r      <= step_nxt;
      sep_any_r   <= sep_any_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_ovl_r <= out_ovl_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_overlapping = out_ovl_r;

endmodule

`default_nettype wire

@@ verif/obb_scoreboard_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the oriented box overlap test: keeps its own copy of the corner store,
// predicts the overlap verdict of each test word and checks the result words in order.
// Depends on obb_pkg for the coordinate width and the corner store depth.

package obb_scoreboard_pkg;

  localparam int CW = obb_pkg::COORD_BITS_DEF;

  class obb_scoreboard;
    logic signed [CW-1:0] store_x [obb_pkg::CORNER_DEPTH];
    logic signed [CW-1:0] store_y [obb_pkg::CORNER_DEPTH];
    bit overlap_expected [$];
    int mismatches;

    function new();
      mismatches = 0;
      foreach (store_x[i]) begin
        store_x[i] = '0;
        store_y[i] = '0;
      end
    endfunction

    function void span(int base, longint ax, longint ay, output longint lo, output longint hi);
      longint p;
      lo = 0;
      hi = 0;
      for (int i = 0; i < 4; i++) begin
        p = longint'(store_x[base+i]) * ax + longint'(store_y[base+i]) * ay;
        if (i == 0 || p < lo) lo = p;
        if (i == 0 || p > hi) hi = p;
      end
    endfunction

    // Axes are the edges c3-c2 and c2-c1 of each rectangle, left unnormalized.
    function bit overlap_verdict();
      int base;
      int e;
      longint ax, ay, lo_a, hi_a, lo_b, hi_b;
      for (int k = 0; k < 4; k++) begin
        base = (k / 2) * 4;
        e = (k % 2 == 1) ? 2 : 3;
        ax = longint'(store_x[base+e]) - longint'(store_x[base+e-1]);
        ay = longint'(store_y[base+e]) - longint'(store_y[base+e-1]);
        span(0, ax, ay, lo_a, hi_a);
        span(4, ax, ay, lo_b, hi_b);
        if (hi_a < lo_b || hi_b < lo_a) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_word(bit box, bit [1:0] idx, logic signed [CW-1:0] x,
                            logic signed [CW-1:0] y, bit last);
      int slot;
      slot = box * 4 + idx;
      store_x[slot] = x;
      store_y[slot] = y;
      if (last) overlap_expected.push_back(overlap_verdict());
    endfunction

    function void check_result(logic got);
      bit want;
      if (overlap_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result word overlapping=%0b arrived with none expected", got);
        return;
      end
      want = overlap_expected.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: overlapping expected %0b, got %0b", want, got);
      end
    endfunction

    function int pending();
      return overlap_expected.size();
    endfunction
  endclass

endpackage

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Top-level testbench for oriented_box_overlap_test: directed and random rectangle pairs
// under several idle and stall mixes, checked by the scoreboard in obb_scoreboard_pkg.
// Depends on obb_pkg, obb_scoreboard_pkg and the block's RTL.

module tb;

  localparam int CW = obb_scoreboard_pkg::CW;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 450;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_box_select = 1'b0;
  logic [1:0] in_corner_index = '0;
  logic signed [CW-1:0] in_corner_x = '0;
  logic signed [CW-1:0] in_corner_y = '0;
  logic in_last_corner = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_overlapping;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;
  int words_sent = 0;
  logic signed [CW-1:0] pair_x [8];
  logic signed [CW-1:0] pair_y [8];
  int order [8];
  obb_scoreboard_pkg::obb_scoreboard board;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  oriented_box_overlap_test uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_box_select(in_box_select),
    .in_corner_index(in_corner_index),
    .in_corner_x(in_corner_x),
    .in_corner_y(in_corner_y),
    .in_last_corner(in_last_corner),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_overlapping(out_overlapping)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("oriented_box_overlap_test test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        board.note_word(in_box_select, in_corner_index, in_corner_x, in_corner_y,
                        in_last_corner);
      if (out_valid && !out_stall) board.check_result(out_overlapping);
    end
  end

  task automatic send_word(bit box, bit [1:0] idx, logic signed [CW-1:0] x,
                           logic signed [CW-1:0] y, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_box_select <= box;
    in_corner_index <= idx;
    in_corner_x <= x;
    in_corner_y <= y;
    in_last_corner <= last;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic send_quad(bit box, int x0, int y0, int x1, int y1, int x2, int y2,
                           int x3, int y3, bit last);
    int qx [4];
    int qy [4];
    qx = '{x0, x1, x2, x3};
    qy = '{y0, y1, y2, y3};
    for (int k = 0; k < 4; k++)
      send_word(box, 2'(k), CW'(qx[k]), CW'(qy[k]), last && k == 3);
  endtask

  function automatic logic signed [CW-1:0] clamp_coord(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return CW'(v);
  endfunction

  // Corners wind as center -a*u -b*v, +a*u -b*v, +a*u +b*v, -a*u +b*v, with v = u rotated.
  task automatic build_rect(int base, int cx, int cy, int reach);
    int ux, uy, a, b, sa, sb;
    ux = int'($urandom_range(32)) - 16;
    uy = int'($urandom_range(32)) - 16;
    a = $urandom_range(reach);
    b = $urandom_range(reach);
    for (int k = 0; k < 4; k++) begin
      sa = (k == 1 || k == 2) ? 1 : -1;
      sb = (k >= 2) ? 1 : -1;
      pair_x[base+k] = clamp_coord(cx + sa * a * ux - sb * b * uy);
      pair_y[base+k] = clamp_coord(cy + sa * a * uy + sb * b * ux);
    end
  endtask

  task automatic build_pair();
    int cx, cy, reach, j, t;
    reach = ($urandom_range(9) == 0) ? 600 : 24;
    cx = int'($urandom_range(40000)) - 20000;
    cy = int'($urandom_range(40000)) - 20000;
    build_rect(0, cx, cy, reach);
    build_rect(4, cx + int'($urandom_range(2400)) - 1200,
               cy + int'($urandom_range(2400)) - 1200, reach);
    for (int k = 0; k < 8; k++) order[k] = k;
    for (int k = 7; k > 0; k--) begin
      j = $urandom_range(k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
  endtask

  task automatic send_pair(int count, bit last);
    for (int k = 0; k < count; k++)
      send_word(order[k][2], order[k][1:0], pair_x[order[k]], pair_y[order[k]],
                last && k == count - 1);
  endtask

  initial begin
    int goal;
    int pick;
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_quad(1'b0, 0, 0, 256, 0, 256, 256, 0, 256, 1'b0);
    send_quad(1'b1, 128, 128, 384, 128, 384, 384, 128, 384, 1'b1);
    send_quad(1'b1, 256, 0, 512, 0, 512, 256, 256, 256, 1'b1);
    send_quad(1'b1, 257, 0, 513, 0, 513, 256, 257, 256, 1'b1);
    send_quad(1'b0, -32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767, 1'b1);
    send_quad(1'b0, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 1'b1);

    goal = words_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 68; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 68; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      goal += RANDOM_WORDS / 4;
      while (words_sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          build_pair();
          send_pair(8, 1'b1);
        end else if (pick < 88) begin
          build_pair();
          send_pair($urandom_range(1, 7), 1'($urandom_range(1)));
        end else begin
          send_word(1'($urandom_range(1)), 2'($urandom_range(3)), CW'($urandom()),
                    CW'($urandom()), $urandom_range(3) == 0);
        end
      end
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("oriented_box_overlap_test test passed");
    end else begin
      $display("oriented_box_overlap_test test failed");
    end
    $finish;
  end

endmodule
